[hdl/ircl_pkg.sv]
// Package for the IR code learn and match block.
// Holds the sequencer state type, item kinds, register indexes, word field
// positions and the table write request; no dependencies.
package ircl_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PREP   = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_COMMIT = 8'b0000_1000,
    S_ELAP   = 8'b0001_0000,
    S_REM    = 8'b0010_0000,
    S_MUL    = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_LEARN = 2'd2;
  localparam logic [1:0] KIND_WRITE = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LEARN_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_DUP_IGNORE    = 2'd1;
  localparam logic [1:0] CFG_POST_IGNORE   = 2'd2;

  // Register reset values.
  localparam logic [31:0] LEARN_TIMEOUT_RST = 32'd10000;
  localparam logic [31:0] DUP_IGNORE_RST    = 32'd1000;
  localparam logic [31:0] POST_IGNORE_RST   = 32'd1000;

  // Division by 1000 for a 32-bit value: (x * MS_RECIP) >> RECIP_SHIFT.
  localparam int unsigned   RECIP_SHIFT = 38;
  localparam logic [28:0]   MS_RECIP    = 29'd274877907;

  // Input tdata field positions.
  localparam int unsigned IN_KEY_LSB   = 0;
  localparam int unsigned IN_PROTO_LSB = 3;
  localparam int unsigned IN_CODE_LSB  = 11;
  localparam int unsigned IN_REP_BIT   = 75;
  localparam int unsigned IN_DATA_W    = 80;

  // Output tdata field positions.
  localparam int unsigned OUT_EVENT_LSB   = 0;
  localparam int unsigned OUT_LEARN_BIT   = 4;
  localparam int unsigned OUT_SLOT_LSB    = 5;
  localparam int unsigned OUT_DUP_LSB     = 8;
  localparam int unsigned OUT_STORED_BIT  = 12;
  localparam int unsigned OUT_LTOTAL_LSB  = 13;
  localparam int unsigned OUT_RTOTAL_LSB  = 45;
  localparam int unsigned OUT_PROTO_LSB   = 77;
  localparam int unsigned OUT_VALUE_LSB   = 85;
  localparam int unsigned OUT_SECS_LSB    = 149;
  localparam int unsigned OUT_SECS_MSB    = 171;
  localparam int unsigned OUT_DATA_W      = 176;

  // Table write request, sized for the largest table; the table slices it.
  typedef struct packed {
    logic        en;
    logic [5:0]  addr;
    logic [7:0]  proto;
    logic [63:0] code;
  } tbl_wr_t;

endpackage

[hdl/ircl_table.sv]
// Key table of the IR code learn and match block: protocol and code memories
// with one write port, one registered read port and per-entry valid bits.
// Depends on ircl_pkg.
module ircl_table #(
  parameter int KEY_SLOTS = 8,
  parameter int CODE_BITS = 64,
  parameter int IDX_W     = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ircl_pkg::tbl_wr_t    wr,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [7:0]           rd_proto,
  output logic [CODE_BITS-1:0] rd_code
);
  import ircl_pkg::*;

  logic [7:0]           mem_proto [KEY_SLOTS];
  logic [CODE_BITS-1:0] mem_code  [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] vld;
  logic [7:0]           q_proto;
  logic [CODE_BITS-1:0] q_code;
  logic                 q_vld;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_proto[wr.addr[IDX_W-1:0]] <= wr.proto;
      mem_code[wr.addr[IDX_W-1:0]]  <= wr.code[CODE_BITS-1:0];
    end
    if (rd_en) begin
      q_proto <= mem_proto[rd_addr];
      q_code  <= mem_code[rd_addr];
    end
  end

  // Valid bits; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr[IDX_W-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        q_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_proto = q_vld ? q_proto : '0;
  assign rd_code  = q_vld ? q_code : '0;

endmodule

[hdl/ircl_secs.sv]
// Seconds-left unit of the IR code learn and match block: a registered
// reciprocal multiply that divides the remaining milliseconds by 1000.
// Depends on ircl_pkg.
module ircl_secs (
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] rem_ms,
  output logic [22:0] secs
);
  import ircl_pkg::*;

  logic [60:0] prod;

  // One multiply, registered.
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= 61'(rem_ms) * 61'(MS_RECIP);
    end
  end

  assign secs = prod[RECIP_SHIFT+22:RECIP_SHIFT];

endmodule

[hdl/ir_code_learn_match_top.sv]
// Top level of the IR code learn and match block: item sequencer, registers
// and output word register. Depends on ircl_pkg, ircl_table and ircl_secs.
//
// Usage: input words arrive on s_tvalid/s_tready with the item kind on s_tuser
// (tick, decoded frame, start learning, key entry write) and the remaining
// fields on s_tdata. Every item gives exactly one result word on
// m_tvalid/m_tready showing the state after that item. The user must write
// registers through cfg_we/cfg_index/cfg_data only while the block is idle;
// the block does not enforce this. Timing: one item at a time. A frame that
// reaches the table walks the slots through the single table read port and
// compare, one slot per cycle, then all items pass the same closing steps.
// The seconds-left figure passes a registered multiplier.
// s_tready is high only while the sequencer is idle. A finished result sits
// in the output register; the next item is accepted while it waits, and that
// item's work stalls at its final step until the receiver takes the word.
// Reset clears the table valid bits, all counters and flags, and restores the
// register defaults; no result is pending after reset.
module ir_code_learn_match_top #(
  parameter int KEY_SLOTS = 8,
  parameter int CODE_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  // Input word.
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: key_sel[2:0], protocol[10:3], code[74:11], repeat_req[75], zero pad
  input  logic [79:0]  s_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]   s_tuser,
  // Result word.
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: event_res[3:0], learning_on[4], learn_slot[7:5], duplicate_slot[11:8],
  // learned_now[12], learned_total[44:13], rejected_total[76:45],
  // last_proto[84:77], last_value[148:85], seconds_left[171:149], zero pad
  output logic [175:0] m_tdata,
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import ircl_pkg::*;

  localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int DUP_W = $clog2(KEY_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);
  localparam logic [63:0] CODE_MASK =
    (CODE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << CODE_BITS) - 64'd1);

  state_t state;

  // Registers.
  logic [31:0] learn_timeout_ms;
  logic [31:0] duplicate_ignore_ms;
  logic [31:0] post_learn_quiet_ms;

  // Latched item.
  logic [1:0]  item_kind;
  logic [2:0]  item_key;
  logic [7:0]  item_proto;
  logic [63:0] item_code;
  logic        item_rep;

  // Block state.
  logic             learning;
  logic [2:0]       learning_slot;
  logic [31:0]      learn_start_ms;
  logic [31:0]      now_ms;
  logic [31:0]      ignore_end_ms;
  logic             ignore_active;
  logic [DUP_W-1:0] dup_slot;
  logic [31:0]      learn_count;
  logic [31:0]      reject_count;
  logic [7:0]       prev_protocol;
  logic [63:0]      prev_code;

  // Per-item working registers.
  logic [3:0]       event_r;
  logic             stored;
  logic [IDX_W-1:0] scan_idx;
  logic             issue_done;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic [31:0]      elapsed;
  logic [31:0]      rem_ms;

  // Table and seconds unit connections.
  tbl_wr_t              tbl_wr;
  logic                 tbl_rd_en;
  logic [7:0]           tbl_proto;
  logic [CODE_BITS-1:0] tbl_code;
  logic [22:0]          secs;

  logic         key_ok;
  logic         slot_ok;
  logic         frame_ok;
  logic [31:0]  win_diff;
  logic         hit;
  logic         time_up;
  logic         learning_after;
  logic         scan_go;
  logic [175:0] word_next;

  assign key_ok   = 32'(item_key) < 32'(KEY_SLOTS);
  assign slot_ok  = 32'(learning_slot) < 32'(KEY_SLOTS);
  assign frame_ok = !item_rep && (item_proto != 8'd0) && (item_code != 64'd0);
  assign win_diff = now_ms - ignore_end_ms;
  assign time_up  = elapsed >= learn_timeout_ms;
  assign learning_after = learning && !((item_kind == KIND_TICK) && time_up);

  // A valid frame outside the ignore window goes on to the table walk.
  assign scan_go = (item_kind == KIND_FRAME) && frame_ok &&
                   !(ignore_active && win_diff[31]);

  // Shared compare of one table entry against the frame; the learning slot is
  // skipped while learning so that relearning the same key is allowed.
  assign hit = cmp_vld && (tbl_proto == item_proto) && (64'(tbl_code) == item_code) &&
               !(learning && (7'(cmp_idx) == 7'(learning_slot)));

  assign s_tready  = (state == S_IDLE) && !rst;
  assign tbl_rd_en = (state == S_SCAN) && !issue_done;

  // Table write: a direct key entry write or a successful learn.
  always_comb begin
    tbl_wr = '0;
    if ((state == S_PREP) && (item_kind == KIND_WRITE) && key_ok) begin
      tbl_wr.en    = 1'b1;
      tbl_wr.addr  = 6'(item_key);
      tbl_wr.proto = item_proto;
      tbl_wr.code  = item_code;
    end else if ((state == S_COMMIT) && learning && !found && slot_ok) begin
      tbl_wr.en    = 1'b1;
      tbl_wr.addr  = 6'(learning_slot);
      tbl_wr.proto = item_proto;
      tbl_wr.code  = item_code;
    end
  end

  // Result word fields, packed from the low bits up.
  always_comb begin
    word_next = '0;
    word_next[OUT_EVENT_LSB +: 4]        = event_r;
    word_next[OUT_LEARN_BIT]             = learning;
    word_next[OUT_SLOT_LSB +: 3]         = learning_slot;
    word_next[OUT_DUP_LSB +: 4]          = 4'(dup_slot);
    word_next[OUT_STORED_BIT]            = stored;
    word_next[OUT_LTOTAL_LSB +: 32]      = learn_count;
    word_next[OUT_RTOTAL_LSB +: 32]      = reject_count;
    word_next[OUT_PROTO_LSB +: 8]        = prev_protocol;
    word_next[OUT_VALUE_LSB +: 64]       = prev_code;
    word_next[OUT_SECS_MSB:OUT_SECS_LSB] = secs;
  end

  ircl_table #(
    .KEY_SLOTS (KEY_SLOTS),
    .CODE_BITS (CODE_BITS),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr       (tbl_wr),
    .rd_en    (tbl_rd_en),
    .rd_addr  (scan_idx),
    .rd_proto (tbl_proto),
    .rd_code  (tbl_code)
  );

  ircl_secs u_secs (
    .clk    (clk),
    .load   (state == S_MUL),
    .rem_ms (rem_ms),
    .secs   (secs)
  );

  // Sequencer and block state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      learn_timeout_ms     <= LEARN_TIMEOUT_RST;
      duplicate_ignore_ms  <= DUP_IGNORE_RST;
      post_learn_quiet_ms  <= POST_IGNORE_RST;
      learning             <= 1'b0;
      learning_slot        <= '0;
      learn_start_ms       <= '0;
      now_ms               <= '0;
      ignore_end_ms        <= '0;
      ignore_active        <= 1'b0;
      dup_slot             <= DUP_W'(KEY_SLOTS);
      learn_count          <= '0;
      reject_count         <= '0;
      prev_protocol        <= '0;
      prev_code            <= '0;
      m_tvalid             <= 1'b0;
      issue_done           <= 1'b0;
      cmp_vld              <= 1'b0;
      found                <= 1'b0;
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEARN_TIMEOUT: learn_timeout_ms     <= cfg_data;
          CFG_DUP_IGNORE:    duplicate_ignore_ms  <= cfg_data;
          CFG_POST_IGNORE:   post_learn_quiet_ms  <= cfg_data;
          default: ;
        endcase
      end

      // A taken word frees the output register unless a new one loads now.
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            item_kind  <= s_tuser;
            item_key   <= s_tdata[IN_KEY_LSB +: 3];
            item_proto <= s_tdata[IN_PROTO_LSB +: 8];
            item_code  <= s_tdata[IN_CODE_LSB +: 64] & CODE_MASK;
            item_rep   <= s_tdata[IN_REP_BIT];
            state      <= S_PREP;
          end
        end

        S_PREP: begin
          event_r <= '0;
          stored  <= 1'b0;
          state   <= scan_go ? S_SCAN : S_ELAP;
          case (item_kind)
            KIND_TICK: begin
              now_ms <= now_ms + 32'd1;
            end
            KIND_FRAME: begin
              if (frame_ok) begin
                prev_protocol <= item_proto;
                prev_code     <= item_code;
                // Inside the ignore window the frame is dropped.
                if (!(ignore_active && win_diff[31])) begin
                  ignore_active <= 1'b0;
                  scan_idx      <= '0;
                  issue_done    <= 1'b0;
                  cmp_vld       <= 1'b0;
                  found         <= 1'b0;
                end
              end
            end
            KIND_LEARN: begin
              if (key_ok) begin
                learning       <= 1'b1;
                learning_slot  <= item_key;
                learn_start_ms <= now_ms;
                dup_slot       <= DUP_W'(KEY_SLOTS);
                ignore_active  <= 1'b0;
                ignore_end_ms  <= '0;
                prev_protocol  <= '0;
                prev_code      <= '0;
              end
            end
            default: ;
          endcase
        end

        // Read one slot per cycle, compare the one read the cycle before.
        S_SCAN: begin
          if (!issue_done) begin
            if (scan_idx == LAST_IDX) begin
              issue_done <= 1'b1;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
          cmp_vld <= !issue_done;
          cmp_idx <= scan_idx;
          if (hit && !found) begin
            found     <= 1'b1;
            found_idx <= cmp_idx;
          end
          if (cmp_vld && (cmp_idx == LAST_IDX)) begin
            state <= S_COMMIT;
          end
        end

        S_COMMIT: begin
          if (learning) begin
            if (found) begin
              // Another key holds this code: reject and open the window.
              dup_slot      <= DUP_W'(found_idx);
              reject_count  <= reject_count + 32'd1;
              ignore_end_ms <= now_ms + duplicate_ignore_ms;
              ignore_active <= 1'b1;
            end else begin
              dup_slot      <= DUP_W'(KEY_SLOTS);
              learning      <= 1'b0;
              learn_count   <= learn_count + 32'd1;
              stored        <= 1'b1;
              ignore_end_ms <= now_ms + post_learn_quiet_ms;
              ignore_active <= 1'b1;
            end
          end else if (found) begin
            event_r <= 4'(7'(found_idx) + 7'd1);
          end
          state <= S_ELAP;
        end

        S_ELAP: begin
          elapsed <= now_ms - learn_start_ms;
          state   <= S_REM;
        end

        // Timeout check on ticks, and the remaining time for the result.
        S_REM: begin
          if (learning && (item_kind == KIND_TICK) && time_up) begin
            learning <= 1'b0;
            dup_slot <= DUP_W'(KEY_SLOTS);
          end
          rem_ms <= (learning_after && !time_up) ? (learn_timeout_ms - elapsed) : '0;
          state  <= S_MUL;
        end

        S_MUL: begin
          state <= S_FINISH;
        end

        // Load the result word once the output register is free.
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= word_next;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/ircl_check.sv]
// Port checker for the IR code learn and match block, bound to the top level.
// Depends on ircl_pkg and ir_code_learn_match_top.
module ircl_check (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [175:0] m_tdata
);
  import ircl_pkg::*;

  // An accepted word keeps the input closed for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after an accepted word");

  // A stored code always ends learning mode.
  a_learn_ends: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[OUT_STORED_BIT]) |-> !m_tdata[OUT_LEARN_BIT])
    else $error("learned_now with learning still on");

  // No time is left outside learning mode.
  a_secs_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[OUT_LEARN_BIT]) |-> (m_tdata[OUT_SECS_MSB:OUT_SECS_LSB] == 23'd0))
    else $error("seconds_left nonzero while not learning");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result word changed while stalled");

endmodule

bind ir_code_learn_match_top ircl_check u_ircl_check (.*);

[tb/tb_ir_code_learn_match_top.sv]
// Self-checking testbench for ir_code_learn_match_top: a directed table of words followed
// by constrained-free random sequences, each result checked against its row or the predictor.
// Depends on ircl_pkg and the ir_code_learn_match_top RTL.
`timescale 1ns / 100ps

module tb_ir_code_learn_match_top;
  import ircl_pkg::*;

  localparam int          KEY_SLOTS     = 8;
  localparam logic [3:0]  NO_SLOT       = 4'd8;
  localparam logic [31:0] MS_PER_S      = 32'd1000;
  localparam int          SETTLE_CYCLES = 40;
  localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TOP_BIT       = 64'h8000_0000_0000_0000;

  // One input item; key sits in the lowest bits as on s_tdata.
  typedef struct packed {
    logic [1:0]  kind;
    logic        rep;
    logic [63:0] code;
    logic [7:0]  proto;
    logic [2:0]  key;
  } ir_item_t;

  // One result word, laid out as m_tdata[171:0].
  typedef struct packed {
    logic [22:0] secs_left;
    logic [63:0] last_value;
    logic [7:0]  last_proto;
    logic [31:0] rejected_total;
    logic [31:0] learned_total;
    logic        learned_now;
    logic [3:0]  duplicate_slot;
    logic [2:0]  learn_slot;
    logic        learning_on;
    logic [3:0]  event_res;
  } code_result_t;

  // Directed table row; want is used only where typed is set.
  typedef struct {
    ir_item_t     it;
    bit           typed;
    code_result_t want;
  } plan_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [79:0]  s_tdata = '0;
  logic [1:0]   s_tuser = KIND_TICK;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [175:0] m_tdata;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = CFG_LEARN_TIMEOUT;
  logic [31:0]  cfg_data = '0;

  ir_code_learn_match_top #(
    .KEY_SLOTS(KEY_SLOTS),
    .CODE_BITS(64)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the key table, timers, counters and registers.
  logic [7:0]  tbl_proto [KEY_SLOTS];
  logic [63:0] tbl_code  [KEY_SLOTS];
  logic        learn_active;
  logic [2:0]  learn_key;
  logic [31:0] learn_t0;
  logic [31:0] ms_now;
  logic [31:0] quiet_until;
  logic        quiet_on;
  logic [3:0]  dup_key;
  logic [31:0] n_learned;
  logic [31:0] n_rejected;
  logic [7:0]  last_p;
  logic [63:0] last_c;
  logic [31:0] cfg_timeout;
  logic [31:0] cfg_dup_quiet;
  logic [31:0] cfg_post_quiet;

  code_result_t  result_q [$];
  plan_row_t     plan [$];
  int unsigned   n_fail = 0;
  int unsigned   n_live = 0;
  int unsigned   rx_seen = 0;
  int unsigned   rx_hold = 0;
  int unsigned   long_at = 250;
  bit            tx_no_gap = 1'b0;
  logic [7:0]    pool_p [6];
  logic [63:0]   pool_c [6];

  // Apply one item to the predictor state and return the word it should produce.
  function automatic code_result_t code_table_step(ir_item_t it);
    code_result_t r;
    logic [3:0]   other;
    logic [3:0]   hit;
    logic         drop;
    logic [31:0]  diff;
    logic [31:0]  elapsed;
    logic [31:0]  left;
    int           i;
    r = '0;
    case (it.kind)
      KIND_TICK: begin
        ms_now = ms_now + 32'd1;
        if (learn_active && (ms_now - learn_t0) >= cfg_timeout) begin
          learn_active = 1'b0;
          dup_key = NO_SLOT;
        end
      end
      KIND_FRAME: begin
        if (!it.rep && it.proto != 8'd0 && it.code != 64'd0) begin
          drop = 1'b0;
          last_p = it.proto;
          last_c = it.code;
          // Inside the window while the wrapped difference is negative.
          if (quiet_on) begin
            diff = ms_now - quiet_until;
            if (diff[31]) drop = 1'b1;
            else quiet_on = 1'b0;
          end
          if (!drop && learn_active) begin
            other = NO_SLOT;
            for (i = KEY_SLOTS - 1; i >= 0; i--) begin
              if (i != learn_key && tbl_proto[i] == it.proto && tbl_code[i] == it.code)
                other = i[3:0];
            end
            if (other != NO_SLOT) begin
              dup_key = other;
              n_rejected = n_rejected + 32'd1;
              quiet_until = ms_now + cfg_dup_quiet;
              quiet_on = 1'b1;
            end else begin
              dup_key = NO_SLOT;
              tbl_proto[learn_key] = it.proto;
              tbl_code[learn_key] = it.code;
              learn_active = 1'b0;
              n_learned = n_learned + 32'd1;
              r.learned_now = 1'b1;
              quiet_until = ms_now + cfg_post_quiet;
              quiet_on = 1'b1;
            end
          end else if (!drop) begin
            hit = 4'd0;
            for (i = KEY_SLOTS - 1; i >= 0; i--) begin
              if (tbl_proto[i] == it.proto && tbl_code[i] == it.code && tbl_code[i] != 64'd0)
                hit = i[3:0] + 4'd1;
            end
            r.event_res = hit;
          end
        end
      end
      KIND_LEARN: begin
        learn_active = 1'b1;
        learn_key = it.key;
        learn_t0 = ms_now;
        dup_key = NO_SLOT;
        quiet_on = 1'b0;
        quiet_until = 32'd0;
        last_p = 8'd0;
        last_c = 64'd0;
      end
      default: begin
        tbl_proto[it.key] = it.proto;
        tbl_code[it.key] = it.code;
      end
    endcase
    r.learning_on    = learn_active;
    r.learn_slot     = learn_key;
    r.duplicate_slot = dup_key;
    r.learned_total  = n_learned;
    r.rejected_total = n_rejected;
    r.last_proto     = last_p;
    r.last_value     = last_c;
    elapsed = ms_now - learn_t0;
    if (learn_active && elapsed < cfg_timeout) begin
      left = (cfg_timeout - elapsed) / MS_PER_S;
      r.secs_left = left[22:0];
    end
    return r;
  endfunction

  function automatic ir_item_t mk_item(logic [1:0] kind, logic [2:0] key, logic [7:0] proto,
                                       logic [63:0] code, logic rep);
    ir_item_t it;
    it.kind = kind;
    it.key = key;
    it.proto = proto;
    it.code = code;
    it.rep = rep;
    return it;
  endfunction

  function automatic code_result_t mk_res(logic [3:0] ev, logic lrn, logic [2:0] slot,
                                          logic [3:0] dup, logic stored, logic [31:0] ltot,
                                          logic [31:0] rtot, logic [7:0] p, logic [63:0] v,
                                          logic [22:0] secs);
    code_result_t r;
    r.event_res = ev;
    r.learning_on = lrn;
    r.learn_slot = slot;
    r.duplicate_slot = dup;
    r.learned_now = stored;
    r.learned_total = ltot;
    r.rejected_total = rtot;
    r.last_proto = p;
    r.last_value = v;
    r.secs_left = secs;
    return r;
  endfunction

  function automatic void add_row(logic [1:0] kind, logic [2:0] key, logic [7:0] proto,
                                  logic [63:0] code, logic rep, bit typed, code_result_t want);
    plan_row_t row;
    row.it = mk_item(kind, key, proto, code, rep);
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long gap.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand_code();
    logic [63:0] c;
    case ($urandom_range(0, 3))
      0: c = 64'd1 << $urandom_range(0, 63);
      1: c = ALL_ONES;
      default: c = {$urandom, $urandom};
    endcase
    if (c == 64'd0) c = 64'd1;
    return c;
  endfunction

  // Offer one word, wait for the handshake, then record what it should produce.
  task automatic send_word(ir_item_t it, bit typed, code_result_t want);
    int unsigned  gap;
    code_result_t pred;
    gap = tx_no_gap ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= {4'b0, it.rep, it.code, it.proto, it.key};
    do @(posedge clk); while (!s_tready);
    pred = code_table_step(it);
    result_q.push_back(typed ? want : pred);
    if (!(it.kind == KIND_FRAME && (it.rep || it.proto == 8'd0 || it.code == 64'd0)))
      n_live++;
  endtask

  task automatic offer(logic [1:0] kind, logic [2:0] key, logic [7:0] proto,
                       logic [63:0] code, logic rep);
    send_word(mk_item(kind, key, proto, code, rep), 1'b0, '0);
  endtask

  // Stop offering and let every outstanding result word come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic set_regs(logic [31:0] tmo, logic [31:0] dupq, logic [31:0] postq);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LEARN_TIMEOUT;
    cfg_data  <= tmo;
    @(posedge clk);
    cfg_timeout = tmo;
    cfg_index <= CFG_DUP_IGNORE;
    cfg_data  <= dupq;
    @(posedge clk);
    cfg_dup_quiet = dupq;
    cfg_index <= CFG_POST_IGNORE;
    cfg_data  <= postq;
    @(posedge clk);
    cfg_post_quiet = postq;
    cfg_we <= 1'b0;
  endtask

  // Fresh set of codes per phase; the last two differ only in protocol.
  task automatic refill_pool();
    int i;
    for (i = 0; i < 6; i++) begin
      pool_p[i] = $urandom_range(1, 254);
      pool_c[i] = rand_code();
    end
    pool_c[5] = pool_c[4];
    pool_p[5] = pool_p[4] + 8'd1;
  endtask

  // Random sequences: learn attempts, matches, tick runs, table writes and noise.
  task automatic run_random(int unsigned target, int unsigned tick_span);
    int unsigned stop;
    int unsigned r;
    int unsigned j;
    int unsigned n;
    logic [7:0]  p;
    logic [63:0] c;
    refill_pool();
    stop = n_live + target;
    while (n_live < stop) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        offer(KIND_LEARN, $urandom_range(0, KEY_SLOTS - 1), $urandom, {$urandom, $urandom},
              $urandom_range(0, 1));
        n = $urandom_range(0, tick_span);
        repeat (n) offer(KIND_TICK, $urandom, $urandom, {$urandom, $urandom}, $urandom);
        j = $urandom_range(0, 5);
        offer(KIND_FRAME, $urandom, pool_p[j], pool_c[j], 1'b0);
        if ($urandom_range(0, 2) == 0) begin
          j = $urandom_range(0, 5);
          offer(KIND_FRAME, $urandom, pool_p[j], pool_c[j], 1'b0);
        end
      end else if (r < 60) begin
        j = $urandom_range(0, 5);
        offer(KIND_FRAME, $urandom, pool_p[j], pool_c[j], $urandom_range(0, 9) == 0);
      end else if (r < 72) begin
        n = $urandom_range(1, tick_span + 1);
        repeat (n) offer(KIND_TICK, $urandom, $urandom, {$urandom, $urandom}, $urandom);
      end else if (r < 82) begin
        j = $urandom_range(0, 5);
        if ($urandom_range(0, 1) == 0) begin
          p = pool_p[j];
          c = pool_c[j];
        end else begin
          p = $urandom;
          c = {$urandom, $urandom};
        end
        offer(KIND_WRITE, $urandom_range(0, KEY_SLOTS - 1), p, c, $urandom_range(0, 1));
      end else begin
        p = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        c = ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom};
        offer($urandom_range(0, 3), $urandom, p, c, $urandom_range(0, 1));
      end
    end
  endtask

  // Result word receiver: random stalls, a periodic long hold-off, and stretches
  // where it takes every word.
  always @(posedge clk) begin
    code_result_t got;
    code_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        rx_seen++;
        got = m_tdata[171:0];
        if (result_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("Unexpected result word %h", m_tdata);
        end else begin
          want = result_q.pop_front();
          if (got !== want || m_tdata[175:172] !== 4'd0) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("Mismatch on result word %0d:", rx_seen);
              if (got.event_res !== want.event_res)
                $display("  event_res exp %0d got %0d", want.event_res, got.event_res);
              if (got.learning_on !== want.learning_on)
                $display("  learning_on exp %0d got %0d", want.learning_on, got.learning_on);
              if (got.learn_slot !== want.learn_slot)
                $display("  learn_slot exp %0d got %0d", want.learn_slot, got.learn_slot);
              if (got.duplicate_slot !== want.duplicate_slot)
                $display("  duplicate_slot exp %0d got %0d", want.duplicate_slot,
                         got.duplicate_slot);
              if (got.learned_now !== want.learned_now)
                $display("  learned_now exp %0d got %0d", want.learned_now, got.learned_now);
              if (got.learned_total !== want.learned_total)
                $display("  learned_total exp %0d got %0d", want.learned_total,
                         got.learned_total);
              if (got.rejected_total !== want.rejected_total)
                $display("  rejected_total exp %0d got %0d", want.rejected_total,
                         got.rejected_total);
              if (got.last_proto !== want.last_proto)
                $display("  last_proto exp %h got %h", want.last_proto, got.last_proto);
              if (got.last_value !== want.last_value)
                $display("  last_value exp %h got %h", want.last_value, got.last_value);
              if (got.secs_left !== want.secs_left)
                $display("  seconds_left exp %0d got %0d", want.secs_left, got.secs_left);
              if (m_tdata[175:172] !== 4'd0)
                $display("  pad bits exp 0 got %h", m_tdata[175:172]);
            end
          end
        end
      end
      if (rx_hold != 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else if (rx_seen >= long_at) begin
        // Long hold-off so the block fills up and stalls its input.
        m_tready <= 1'b0;
        rx_hold = 600;
        long_at = long_at + 300;
      end else if (((rx_seen / 64) % 6) == 3) begin
        m_tready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        rx_hold = pick_gap();
        m_tready <= (rx_hold == 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, directed table, then random phases under several settings.
  initial begin
    int i;
    for (i = 0; i < KEY_SLOTS; i++) begin
      tbl_proto[i] = 8'd0;
      tbl_code[i] = 64'd0;
    end
    learn_active = 1'b0;
    learn_key = 3'd0;
    learn_t0 = 32'd0;
    ms_now = 32'd0;
    quiet_until = 32'd0;
    quiet_on = 1'b0;
    dup_key = NO_SLOT;
    n_learned = 32'd0;
    n_rejected = 32'd0;
    last_p = 8'd0;
    last_c = 64'd0;
    cfg_timeout = LEARN_TIMEOUT_RST;
    cfg_dup_quiet = DUP_IGNORE_RST;
    cfg_post_quiet = POST_IGNORE_RST;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Dropped frames: repeat, zero protocol, zero code.
    add_row(KIND_TICK, 3'd0, 8'd0, 64'd0, 1'b0, 1,
            mk_res(0, 0, 0, NO_SLOT, 0, 0, 0, 8'h00, 64'd0, 0));
    add_row(KIND_FRAME, 3'd0, 8'd5, 64'd1, 1'b1, 1,
            mk_res(0, 0, 0, NO_SLOT, 0, 0, 0, 8'h00, 64'd0, 0));
    add_row(KIND_FRAME, 3'd0, 8'd0, 64'd5, 1'b0, 1,
            mk_res(0, 0, 0, NO_SLOT, 0, 0, 0, 8'h00, 64'd0, 0));
    add_row(KIND_FRAME, 3'd0, 8'd5, 64'd0, 1'b0, 1,
            mk_res(0, 0, 0, NO_SLOT, 0, 0, 0, 8'h00, 64'd0, 0));
    // Extreme frame with no match, then stored in the top slot and matched.
    add_row(KIND_FRAME, 3'd0, 8'hFF, ALL_ONES, 1'b0, 1,
            mk_res(0, 0, 0, NO_SLOT, 0, 0, 0, 8'hFF, ALL_ONES, 0));
    add_row(KIND_WRITE, 3'd7, 8'hFF, ALL_ONES, 1'b0, 1,
            mk_res(0, 0, 0, NO_SLOT, 0, 0, 0, 8'hFF, ALL_ONES, 0));
    add_row(KIND_FRAME, 3'd0, 8'hFF, ALL_ONES, 1'b0, 1,
            mk_res(8, 0, 0, NO_SLOT, 0, 0, 0, 8'hFF, ALL_ONES, 0));
    add_row(KIND_WRITE, 3'd0, 8'd1, 64'd1, 1'b0, 1,
            mk_res(0, 0, 0, NO_SLOT, 0, 0, 0, 8'hFF, ALL_ONES, 0));
    add_row(KIND_FRAME, 3'd0, 8'd1, 64'd1, 1'b0, 1,
            mk_res(1, 0, 0, NO_SLOT, 0, 0, 0, 8'h01, 64'd1, 0));
    // Learning: countdown, duplicate rejected, frame dropped in the window.
    add_row(KIND_LEARN, 3'd3, 8'd0, 64'd0, 1'b0, 1,
            mk_res(0, 1, 3, NO_SLOT, 0, 0, 0, 8'h00, 64'd0, 10));
    add_row(KIND_TICK, 3'd0, 8'd0, 64'd0, 1'b0, 1,
            mk_res(0, 1, 3, NO_SLOT, 0, 0, 0, 8'h00, 64'd0, 9));
    add_row(KIND_FRAME, 3'd0, 8'hFF, ALL_ONES, 1'b0, 1,
            mk_res(0, 1, 3, 4'd7, 0, 0, 1, 8'hFF, ALL_ONES, 9));
    add_row(KIND_FRAME, 3'd0, 8'd1, 64'd1, 1'b0, 1,
            mk_res(0, 1, 3, 4'd7, 0, 0, 1, 8'h01, 64'd1, 9));
    // Restart clears the window; a new code is learned.
    add_row(KIND_LEARN, 3'd3, 8'd0, 64'd0, 1'b0, 1,
            mk_res(0, 1, 3, NO_SLOT, 0, 0, 1, 8'h00, 64'd0, 10));
    add_row(KIND_FRAME, 3'd0, 8'h42, TOP_BIT, 1'b0, 1,
            mk_res(0, 0, 3, NO_SLOT, 1, 1, 1, 8'h42, TOP_BIT, 0));
    add_row(KIND_FRAME, 3'd0, 8'h42, TOP_BIT, 1'b0, 0, '0);
    add_row(KIND_WRITE, 3'd3, 8'd0, 64'd0, 1'b0, 0, '0);
    add_row(KIND_LEARN, 3'd5, 8'd0, 64'd0, 1'b0, 0, '0);
    add_row(KIND_FRAME, 3'd0, 8'h42, TOP_BIT, 1'b0, 0, '0);
    add_row(KIND_FRAME, 3'd0, 8'h42, TOP_BIT, 1'b1, 0, '0);
    add_row(KIND_TICK, 3'd0, 8'd0, 64'd0, 1'b0, 0, '0);
    // The slot being learned may already hold the same code.
    add_row(KIND_LEARN, 3'd0, 8'd0, 64'd0, 1'b0, 0, '0);
    add_row(KIND_FRAME, 3'd0, 8'd1, 64'd1, 1'b0, 0, '0);
    add_row(KIND_FRAME, 3'd0, 8'd1, 64'd1, 1'b0, 0, '0);

    foreach (plan[k]) send_word(plan[k].it, plan[k].typed, plan[k].want);

    run_random(100, 20);
    set_regs(32'd20, 32'd8, 32'd5);
    run_random(150, 30);
    set_regs(32'd1, 32'd0, 32'd0);
    run_random(100, 3);
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(100, 20);
    set_regs(32'd3000, 32'h8000_0000, 32'h7FFF_FFFF);
    tx_no_gap = 1'b1;
    run_random(100, 20);
    tx_no_gap = 1'b0;
    set_regs(32'd0, 32'd3, 32'd2);
    run_random(100, 5);
    for (i = 0; i < 2; i++) begin
      set_regs($urandom_range(1, 40), $urandom_range(0, 20), $urandom_range(0, 20));
      run_random(100, 45);
    end

    drain();
    if (n_fail == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
